@@ design/bfg_pkg.sv @@
// bfg_pkg: shared types, constants and level tables of the battery fuel gauge
// no dependencies; imported by every module of the block

package bfg_pkg;

   // stream and register port widths
   localparam int SAMPLE_W   = 12;
   localparam int MV_W       = 14;
   localparam int LEVEL_W    = 7;
   localparam int COUNT_W    = 5;
   localparam int SUM_W      = 16;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   // register reset values
   localparam logic [MV_W-1:0]    LOW_THRESHOLD_RESET  = 14'd3200;
   localparam logic [COUNT_W-1:0] START_REFRESH_RESET  = 5'd30;
   localparam logic [COUNT_W-1:0] CHANGE_REFRESH_RESET = 5'd3;
   localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL_RESET  = 7'd95;

   // published record after reset
   localparam logic [MV_W-1:0]    HELD_MV_RESET    = 14'd3600;
   localparam logic [LEVEL_W-1:0] HELD_LEVEL_RESET = 7'd100;
   localparam logic [LEVEL_W-1:0] FULL_LEVEL       = 7'd100;

   // window average: avg = (sum * ceil(2^20 / len)) >> 20, exact for 16-bit sums
   localparam int DIV_SHIFT  = 20;
   localparam int DIV_MULT_W = DIV_SHIFT + 1;

   // millivolts: mv = (avg * ceil(1000 * 2^21 / 341)) >> 21, exact for 12-bit avg
   localparam int                MV_SHIFT  = 21;
   localparam int                MV_MULT_W = 23;
   localparam logic [MV_MULT_W-1:0] MV_MULT = 23'd6150006;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_START_REFRESH  = 2'd1,
      CSR_CHANGE_REFRESH = 2'd2,
      CSR_DEFAULT_LEVEL  = 2'd3
   } csr_index_type;

   // charging source codes
   typedef enum logic [1:0] {
      SRC_BATTERY = 2'd0,
      SRC_USB     = 2'd1,
      SRC_AC      = 2'd2
   } source_type;

   // front stage to scale stage
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      source_type       src;
      logic             pub;
   } front_item_type;

   // scale stage to record stage
   typedef struct packed {
      logic [MV_W-1:0] mv;
      source_type      src;
      logic            pub;
   } mv_item_type;

   // one voltage range of a level table
   typedef struct packed {
      logic [12:0]        lo;
      logic [12:0]        hi;
      logic [LEVEL_W-1:0] pct;
   } range_type;

   localparam int TABLE_LEN = 56;

   localparam range_type CABLE_TABLE [TABLE_LEN] = '{
      '{4106,4900,100}, '{4100,4105,99}, '{4096,4100,98}, '{4091,4095,97}, '{4086,4090,96},
      '{4081,4085,95},  '{4076,4080,94}, '{4071,4075,93}, '{4066,4070,92}, '{4061,4065,91},
      '{4052,4060,90},  '{4043,4051,89}, '{4036,4042,88}, '{4026,4035,87}, '{4019,4025,86},
      '{4011,4018,85},  '{4003,4010,84}, '{3996,4002,82}, '{3989,3995,82}, '{3981,3988,81},
      '{3971,3980,80},  '{3961,3970,79}, '{3951,3960,78}, '{3941,3950,76}, '{3931,3940,74},
      '{3921,3930,72},  '{3914,3920,70}, '{3906,3913,69}, '{3899,3905,68}, '{3891,3898,66},
      '{3881,3890,64},  '{3871,3880,62}, '{3856,3870,60}, '{3846,3855,57}, '{3836,3845,54},
      '{3821,3835,52},  '{3811,3820,50}, '{3801,3810,47}, '{3791,3800,43}, '{3785,3790,40},
      '{3779,3784,37},  '{3771,3778,33}, '{3766,3770,30}, '{3756,3765,28}, '{3746,3755,26},
      '{3741,3745,23},  '{3726,3740,20}, '{3716,3725,18}, '{3701,3715,16}, '{3691,3700,13},
      '{3681,3690,10},  '{3651,3680,8},  '{3601,3650,5},  '{3441,3600,3},  '{3401,3440,1},
      '{0,3400,0}
   };

   localparam range_type BATTERY_TABLE [TABLE_LEN] = '{
      '{4071,4500,100}, '{4061,4070,99}, '{4051,4060,98}, '{4041,4050,97}, '{4031,4040,96},
      '{4021,4030,95},  '{4016,4020,94}, '{4011,4015,93}, '{4005,4010,92}, '{4001,4005,91},
      '{3985,4000,90},  '{3971,3985,89}, '{3961,3970,88}, '{3951,3960,87}, '{3941,3950,86},
      '{3931,3940,85},  '{3921,3930,84}, '{3911,3920,82}, '{3901,3910,82}, '{3891,3900,81},
      '{3876,3890,80},  '{3861,3875,79}, '{3846,3860,78}, '{3831,3845,76}, '{3821,3830,74},
      '{3811,3820,72},  '{3801,3810,70}, '{3791,3800,69}, '{3781,3790,68}, '{3771,3780,66},
      '{3761,3770,64},  '{3751,3760,62}, '{3741,3750,60}, '{3731,3740,57}, '{3721,3730,54},
      '{3711,3720,52},  '{3701,3710,50}, '{3691,3700,47}, '{3681,3690,43}, '{3671,3680,40},
      '{3661,3670,37},  '{3651,3660,33}, '{3641,3650,30}, '{3631,3640,28}, '{3616,3630,26},
      '{3601,3615,23},  '{3581,3600,20}, '{3561,3580,17}, '{3556,3560,14}, '{3546,3555,11},
      '{3541,3545,8},   '{3501,3540,5},  '{3471,3500,1},  '{3421,3470,0},  '{3401,3420,0},
      '{0,3400,0}
   };

   // parallel range compare, last matching range wins
   function automatic logic [LEVEL_W-1:0] lookup_level(input logic            cable,
                                                       input logic [MV_W-1:0] mv,
                                                       input logic [LEVEL_W-1:0] dflt);
      logic [LEVEL_W-1:0] lvl;
      range_type          rng;
      lvl = dflt;
      for (int i = 0; i < TABLE_LEN; i++) begin
         rng = cable ? CABLE_TABLE[i] : BATTERY_TABLE[i];
         if (mv >= {1'b0, rng.lo} && mv <= {1'b0, rng.hi}) begin
            lvl = rng.pct;
         end
      end
      return lvl;
   endfunction

endpackage

@@ design/battery_fuel_gauge_top.sv @@
// battery_fuel_gauge_top: top level of the battery fuel gauge
// depends on bfg_pkg, bfg_front, bfg_scale, bfg_record

// One request transaction is one tick: three raw 12-bit battery samples and the
// adapter and vbus detect pins. The block returns one result per tick with the
// published voltage, level and charge enable, this tick's source, a publish flag
// and a low-battery flag. A transaction is taken every clock cycle while the result
// side keeps taking results; a stalled result holds the pipeline. An accepted request
// passes four pipeline registers (window update, average multiply, millivolt
// multiply, level lookup into the result register) on its way to the result. The
// refresh countdown loads its reset value of 30 at reset; a write to the start
// refresh register is accepted but has no effect, since the block keeps no start
// refresh register. Configuration registers must be written only while no transaction
// is in flight; the block itself does not enforce this.

module battery_fuel_gauge_top #(
   parameter int WINDOW_LEN = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample_a[11:0], sample_b[23:12], sample_c[35:24], dc_detect[36],
   // vbus_detect[37], zero fill[39:38]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfg_pkg::REQ_DATA_W-1:0]  req_tdata,
   // voltage_mv[13:0], level_percent[20:14], charge_enable[21], source[23:22],
   // published[24], low_battery[25], zero fill[31:26]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bfg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfg_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bfg_pkg::*;

   logic [MV_W-1:0]     low_threshold_ff;
   logic [COUNT_W-1:0]  change_count_ff;
   logic [LEVEL_W-1:0]  default_level_ff;
   logic                front_valid, front_ready, mv_valid, mv_ready;
   front_item_type      front_item;
   mv_item_type         mv_item;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_threshold_ff <= LOW_THRESHOLD_RESET;
         change_count_ff  <= CHANGE_REFRESH_RESET;
         default_level_ff <= DEFAULT_LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOW_THRESHOLD:  low_threshold_ff <= csr_data[MV_W-1:0];
            CSR_START_REFRESH:  ;
            CSR_CHANGE_REFRESH: change_count_ff  <= csr_data[COUNT_W-1:0];
            CSR_DEFAULT_LEVEL:  default_level_ff <= csr_data[LEVEL_W-1:0];
            default:            ;
         endcase
      end
   end

   // window and countdown
   bfg_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_tvalid           (req_tvalid),
      .req_tready           (req_tready),
      .req_tdata            (req_tdata),
      .change_refresh_count (change_count_ff),
      .front_valid          (front_valid),
      .front_ready          (front_ready),
      .front_item           (front_item)
   );

   // average and millivolts
   bfg_scale #(.WINDOW_LEN(WINDOW_LEN)) u_scale (
      .clock       (clock),
      .reset       (reset),
      .front_valid (front_valid),
      .front_ready (front_ready),
      .front_item  (front_item),
      .mv_valid    (mv_valid),
      .mv_ready    (mv_ready),
      .mv_item     (mv_item)
   );

   // level, held record and result
   bfg_record u_record (
      .clock            (clock),
      .reset            (reset),
      .mv_valid         (mv_valid),
      .mv_ready         (mv_ready),
      .mv_item          (mv_item),
      .low_threshold_mv (low_threshold_ff),
      .default_level    (default_level_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule

@@ design/bfg_front.sv @@
// bfg_front: source decode, refresh countdown, median and moving-sum window
// depends on bfg_pkg

module bfg_front #(
   parameter int WINDOW_LEN = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bfg_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [bfg_pkg::COUNT_W-1:0]          change_refresh_count,
   output logic                                 front_valid,
   input  logic                                 front_ready,
   output bfg_pkg::front_item_type              front_item
);
   import bfg_pkg::*;

   localparam int              IDX_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

   logic [SAMPLE_W-1:0] samples_ff [WINDOW_LEN];
   logic [SAMPLE_W-1:0] samples_in [WINDOW_LEN];
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [IDX_W-1:0]    idx_ff, idx_in, idx_next;
   logic [COUNT_W-1:0]  count_ff, count_in, count_eff;
   source_type          prev_src_ff, src;
   logic                valid_ff;
   front_item_type      item_ff, item_in;

   logic [SAMPLE_W-1:0] smp_a, smp_b, smp_c, lo, hi, med;
   logic                accept, refill;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !valid_ff || front_ready;

   // unpack the request transaction
   assign smp_a = req_tdata[SAMPLE_W-1:0];
   assign smp_b = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
   assign smp_c = req_tdata[3*SAMPLE_W-1:2*SAMPLE_W];

   // adapter pin wins over vbus
   always_comb begin
      if (req_tdata[3*SAMPLE_W]) begin
         src = SRC_AC;
      end else if (req_tdata[3*SAMPLE_W+1]) begin
         src = SRC_USB;
      end else begin
         src = SRC_BATTERY;
      end
   end

   // median of three
   always_comb begin
      lo = (smp_a < smp_b) ? smp_a : smp_b;
      hi = (smp_a < smp_b) ? smp_b : smp_a;
      if (smp_c <= lo) begin
         med = lo;
      end else if (smp_c >= hi) begin
         med = hi;
      end else begin
         med = smp_c;
      end
   end

   // countdown, window update and publish decision
   always_comb begin
      count_eff = count_ff;
      if (src != prev_src_ff && count_ff < change_refresh_count) begin
         count_eff = change_refresh_count;
      end
      refill   = (count_eff != '0);
      idx_next = (idx_ff == LAST_IDX) ? '0 : idx_ff + IDX_W'(1);
      samples_in = samples_ff;
      if (refill) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            samples_in[i] = med;
         end
         sum_in   = SUM_W'({{(SUM_W-SAMPLE_W){1'b0}}, med} * SUM_W'(WINDOW_LEN));
         idx_in   = idx_ff;
         count_in = count_eff - COUNT_W'(1);
      end else begin
         samples_in[idx_next] = med;
         sum_in   = sum_ff - {{(SUM_W-SAMPLE_W){1'b0}}, samples_ff[idx_next]}
                           + {{(SUM_W-SAMPLE_W){1'b0}}, med};
         idx_in   = idx_next;
         count_in = count_eff;
      end
      item_in.sum = sum_in;
      item_in.src = src;
      item_in.pub = refill || (idx_in == '0);
   end

   // window state, advanced once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            samples_ff[i] <= '0;
         end
         sum_ff      <= '0;
         idx_ff      <= '0;
         count_ff    <= START_REFRESH_RESET;
         prev_src_ff <= SRC_BATTERY;
      end else if (accept) begin
         samples_ff  <= samples_in;
         sum_ff      <= sum_in;
         idx_ff      <= idx_in;
         count_ff    <= count_in;
         prev_src_ff <= src;
      end
   end

   // stage output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign front_valid = valid_ff;
   assign front_item  = item_ff;

endmodule

@@ design/bfg_scale.sv @@
// bfg_scale: window average and millivolt scaling, one multiply per stage
// depends on bfg_pkg

module bfg_scale #(
   parameter int WINDOW_LEN = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     front_valid,
   output logic                     front_ready,
   input  bfg_pkg::front_item_type  front_item,
   output logic                     mv_valid,
   input  logic                     mv_ready,
   output bfg_pkg::mv_item_type     mv_item
);
   import bfg_pkg::*;

   localparam logic [DIV_MULT_W-1:0] DIV_MULT =
      DIV_MULT_W'(((1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

   logic                         avg_valid_ff, mv_valid_ff, avg_ready;
   logic [SAMPLE_W-1:0]          avg_ff;
   source_type                   avg_src_ff;
   logic                         avg_pub_ff;
   logic [SUM_W+DIV_MULT_W-1:0]  avg_prod;
   logic [SAMPLE_W+MV_MULT_W-1:0] mv_prod;
   mv_item_type                  mv_ff;

   assign avg_ready   = !mv_valid_ff || mv_ready;
   assign front_ready = !avg_valid_ff || avg_ready;

   // average by reciprocal multiply
   assign avg_prod = {{DIV_MULT_W{1'b0}}, front_item.sum} *
                     {{SUM_W{1'b0}}, DIV_MULT};
   // millivolts by combined 1000/341 reciprocal
   assign mv_prod  = {{MV_MULT_W{1'b0}}, avg_ff} * {{SAMPLE_W{1'b0}}, MV_MULT};

   // average stage
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_valid_ff <= 1'b0;
      end else if (front_ready) begin
         avg_valid_ff <= front_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && front_valid) begin
         avg_ff     <= avg_prod[DIV_SHIFT +: SAMPLE_W];
         avg_src_ff <= front_item.src;
         avg_pub_ff <= front_item.pub;
      end
   end

   // millivolt stage
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_valid_ff <= 1'b0;
      end else if (avg_ready) begin
         mv_valid_ff <= avg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (avg_ready && avg_valid_ff) begin
         mv_ff.mv  <= mv_prod[MV_SHIFT +: MV_W];
         mv_ff.src <= avg_src_ff;
         mv_ff.pub <= avg_pub_ff;
      end
   end

   assign mv_valid = mv_valid_ff;
   assign mv_item  = mv_ff;

endmodule

@@ design/bfg_record.sv @@
// bfg_record: level lookup, held record, low flag and result register
// depends on bfg_pkg

module bfg_record (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            mv_valid,
   output logic                            mv_ready,
   input  bfg_pkg::mv_item_type            mv_item,
   input  logic [bfg_pkg::MV_W-1:0]        low_threshold_mv,
   input  logic [bfg_pkg::LEVEL_W-1:0]     default_level,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfg_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import bfg_pkg::*;

   logic [MV_W-1:0]       held_mv_ff, held_mv_in;
   logic [LEVEL_W-1:0]    held_level_ff, held_level_in, level;
   logic                  held_ce_ff, held_ce_in;
   logic                  valid_ff, accept, low;
   logic [RSP_DATA_W-1:0] data_ff, data_in;

   assign mv_ready = !valid_ff || rsp_tready;
   assign accept   = mv_valid && mv_ready;

   // record contents for this transaction
   always_comb begin
      level = lookup_level(mv_item.src != SRC_BATTERY, mv_item.mv, default_level);
      low   = (mv_item.mv <= low_threshold_mv);
      held_mv_in    = held_mv_ff;
      held_level_in = held_level_ff;
      held_ce_in    = held_ce_ff;
      if (mv_item.pub) begin
         held_mv_in    = mv_item.mv;
         held_level_in = level;
         held_ce_in    = (level < FULL_LEVEL) && (mv_item.src != SRC_BATTERY);
      end
      data_in = {6'b0, low, mv_item.pub, mv_item.src, held_ce_in,
                 held_level_in, held_mv_in};
   end

   // published record
   always_ff @(posedge clock) begin
      if (reset) begin
         held_mv_ff    <= HELD_MV_RESET;
         held_level_ff <= HELD_LEVEL_RESET;
         held_ce_ff    <= 1'b0;
      end else if (accept) begin
         held_mv_ff    <= held_mv_in;
         held_level_ff <= held_level_in;
         held_ce_ff    <= held_ce_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (mv_ready) begin
         valid_ff <= mv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

@@ design/bfg_checker.sv @@
// bfg_checker: port-level assertions for battery_fuel_gauge_top, with its bind
// depends on bfg_pkg

module bfg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfg_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import bfg_pkg::*;

   localparam int REC_W   = MV_W + LEVEL_W + 1;
   localparam int CE_BIT  = MV_W + LEVEL_W;
   localparam int SRC_LSB = CE_BIT + 1;
   localparam int PUB_BIT = SRC_LSB + 2;

   logic [REC_W-1:0] last_rec_ff;
   logic             rsp_fire;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   // record seen on the last delivered transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         last_rec_ff <= {1'b0, HELD_LEVEL_RESET, HELD_MV_RESET};
      end else if (rsp_fire) begin
         last_rec_ff <= rsp_tdata[REC_W-1:0];
      end
   end

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an empty result register means the pipeline can take a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // a freshly published charge enable needs a cable and a level below full
   a_charge_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[CE_BIT] && rsp_tdata[PUB_BIT] |->
         rsp_tdata[SRC_LSB +: 2] != SRC_BATTERY &&
         rsp_tdata[MV_W +: LEVEL_W] < FULL_LEVEL)
      else $error("charge enable without cable or at full level");

   // unpublished tick repeats the previous record
   a_record_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[PUB_BIT] |-> rsp_tdata[REC_W-1:0] == last_rec_ff)
      else $error("record changed without publish");

endmodule

bind battery_fuel_gauge_top bfg_checker u_bfg_checker (.*);

@@ tb/sv/bfg_tb_pkg.sv @@
// bfg_tb_pkg: fuel gauge tick predictor and result scoreboard for the testbench
// depends on bfg_pkg for the source codes and register indexes

`timescale 1ns / 1ps

package bfg_tb_pkg;

   import bfg_pkg::*;

   localparam int BAND_COUNT = 56;
   localparam int MV_DIVISOR = 341;

   // percentage bands while a cable is present: low mv, high mv, percent
   localparam int CHARGER_BANDS [BAND_COUNT][3] = '{
      '{4106,4900,100}, '{4100,4105,99}, '{4096,4100,98}, '{4091,4095,97}, '{4086,4090,96},
      '{4081,4085,95},  '{4076,4080,94}, '{4071,4075,93}, '{4066,4070,92}, '{4061,4065,91},
      '{4052,4060,90},  '{4043,4051,89}, '{4036,4042,88}, '{4026,4035,87}, '{4019,4025,86},
      '{4011,4018,85},  '{4003,4010,84}, '{3996,4002,82}, '{3989,3995,82}, '{3981,3988,81},
      '{3971,3980,80},  '{3961,3970,79}, '{3951,3960,78}, '{3941,3950,76}, '{3931,3940,74},
      '{3921,3930,72},  '{3914,3920,70}, '{3906,3913,69}, '{3899,3905,68}, '{3891,3898,66},
      '{3881,3890,64},  '{3871,3880,62}, '{3856,3870,60}, '{3846,3855,57}, '{3836,3845,54},
      '{3821,3835,52},  '{3811,3820,50}, '{3801,3810,47}, '{3791,3800,43}, '{3785,3790,40},
      '{3779,3784,37},  '{3771,3778,33}, '{3766,3770,30}, '{3756,3765,28}, '{3746,3755,26},
      '{3741,3745,23},  '{3726,3740,20}, '{3716,3725,18}, '{3701,3715,16}, '{3691,3700,13},
      '{3681,3690,10},  '{3651,3680,8},  '{3601,3650,5},  '{3441,3600,3},  '{3401,3440,1},
      '{0,3400,0}
   };

   // percentage bands on battery alone
   localparam int BATTERY_BANDS [BAND_COUNT][3] = '{
      '{4071,4500,100}, '{4061,4070,99}, '{4051,4060,98}, '{4041,4050,97}, '{4031,4040,96},
      '{4021,4030,95},  '{4016,4020,94}, '{4011,4015,93}, '{4005,4010,92}, '{4001,4005,91},
      '{3985,4000,90},  '{3971,3985,89}, '{3961,3970,88}, '{3951,3960,87}, '{3941,3950,86},
      '{3931,3940,85},  '{3921,3930,84}, '{3911,3920,82}, '{3901,3910,82}, '{3891,3900,81},
      '{3876,3890,80},  '{3861,3875,79}, '{3846,3860,78}, '{3831,3845,76}, '{3821,3830,74},
      '{3811,3820,72},  '{3801,3810,70}, '{3791,3800,69}, '{3781,3790,68}, '{3771,3780,66},
      '{3761,3770,64},  '{3751,3760,62}, '{3741,3750,60}, '{3731,3740,57}, '{3721,3730,54},
      '{3711,3720,52},  '{3701,3710,50}, '{3691,3700,47}, '{3681,3690,43}, '{3671,3680,40},
      '{3661,3670,37},  '{3651,3660,33}, '{3641,3650,30}, '{3631,3640,28}, '{3616,3630,26},
      '{3601,3615,23},  '{3581,3600,20}, '{3561,3580,17}, '{3556,3560,14}, '{3546,3555,11},
      '{3541,3545,8},   '{3501,3540,5},  '{3471,3500,1},  '{3421,3470,0},  '{3401,3420,0},
      '{0,3400,0}
   };

   // one result transaction split into its fields
   typedef struct {
      logic [13:0] mv;
      logic [6:0]  level;
      logic        charge_en;
      source_type  src;
      logic        pub;
      logic        low_batt;
   } gauge_record_type;

   class fuel_gauge_scoreboard #(int WINDOW_LEN = 1);

      // register copies
      int unsigned low_threshold;
      int unsigned start_count;
      int unsigned change_count;
      int unsigned default_level;

      // gauge state
      int unsigned slots [WINDOW_LEN];
      int unsigned window_total;
      int unsigned slot_pos;
      int unsigned countdown;
      source_type  prior_source;
      int unsigned held_mv;
      int unsigned held_level;
      bit          held_charge_en;

      gauge_record_type expected_records [$];
      int unsigned      mismatches;
      int unsigned      results_seen;

      // state and registers as they come out of reset
      function new();
         low_threshold  = 3200;
         start_count    = 30;
         change_count   = 3;
         default_level  = 95;
         foreach (slots[i]) slots[i] = 0;
         window_total   = 0;
         slot_pos       = 0;
         countdown      = start_count;
         prior_source   = SRC_BATTERY;
         held_mv        = 3600;
         held_level     = 100;
         held_charge_en = 1'b0;
         mismatches     = 0;
         results_seen   = 0;
      endfunction

      // the start count only takes effect at reset, so it is just kept
      function void set_register(csr_index_type idx, logic [13:0] value);
         case (idx)
            CSR_LOW_THRESHOLD:  low_threshold = value;
            CSR_START_REFRESH:  start_count   = value[4:0];
            CSR_CHANGE_REFRESH: change_count  = value[4:0];
            CSR_DEFAULT_LEVEL:  default_level = value[6:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_records.size();
      endfunction

      // predict the result of one accepted tick
      function void note_tick(logic [39:0] item);
         int unsigned      a, b, c, lo, hi, med, avg, mv, lvl;
         int unsigned      band_lo, band_hi, band_pct;
         source_type       src;
         bit               pub;
         gauge_record_type rec;
         a = item[11:0];
         b = item[23:12];
         c = item[35:24];
         src = item[36] ? SRC_AC : (item[37] ? SRC_USB : SRC_BATTERY);

         // a source change forces a short refresh
         if (src != prior_source && countdown < change_count) countdown = change_count;

         // median of the three readings
         lo = (a < b) ? a : b;
         hi = (a < b) ? b : a;
         med = (c <= lo) ? lo : ((c >= hi) ? hi : c);

         // refresh refills the whole window, otherwise slide it by one
         if (countdown > 0) begin
            foreach (slots[i]) slots[i] = med;
            window_total = med * WINDOW_LEN;
         end else begin
            slot_pos = (slot_pos + 1) % WINDOW_LEN;
            window_total -= slots[slot_pos];
            slots[slot_pos] = med;
            window_total += med;
         end
         window_total &= 32'h0000_FFFF;

         avg = window_total / WINDOW_LEN;
         mv  = (avg * 1000) / MV_DIVISOR;
         rec.low_batt = (mv <= low_threshold);

         pub = 1'b0;
         if (countdown > 0) begin
            countdown--;
            pub = 1'b1;
         end else if (slot_pos == 0) begin
            pub = 1'b1;
         end

         // publish: last matching band wins
         if (pub) begin
            lvl = default_level;
            for (int i = 0; i < BAND_COUNT; i++) begin
               if (src == SRC_BATTERY) begin
                  band_lo  = BATTERY_BANDS[i][0];
                  band_hi  = BATTERY_BANDS[i][1];
                  band_pct = BATTERY_BANDS[i][2];
               end else begin
                  band_lo  = CHARGER_BANDS[i][0];
                  band_hi  = CHARGER_BANDS[i][1];
                  band_pct = CHARGER_BANDS[i][2];
               end
               if (mv >= band_lo && mv <= band_hi) lvl = band_pct;
            end
            held_mv        = mv & 32'h3FFF;
            held_level     = lvl & 32'h7F;
            held_charge_en = (held_level < 100) && (src != SRC_BATTERY);
         end
         prior_source = src;

         rec.mv        = held_mv[13:0];
         rec.level     = held_level[6:0];
         rec.charge_en = held_charge_en;
         rec.src       = src;
         rec.pub       = pub;
         expected_records.push_back(rec);
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
         mismatches++;
      endtask

      // compare one accepted result with the oldest prediction
      task check_result(logic [31:0] word);
         gauge_record_type want;
         results_seen++;
         if (expected_records.size() == 0) begin
            report_mismatch("result with nothing pending, data", word, 0);
         end else begin
            want = expected_records.pop_front();
            if (word[13:0] !== want.mv)        report_mismatch("voltage_mv", word[13:0], want.mv);
            if (word[20:14] !== want.level)    report_mismatch("level_percent", word[20:14],
                                                               want.level);
            if (word[21] !== want.charge_en)   report_mismatch("charge_enable", word[21],
                                                               want.charge_en);
            if (word[23:22] !== want.src)      report_mismatch("source", word[23:22], want.src);
            if (word[24] !== want.pub)         report_mismatch("published", word[24], want.pub);
            if (word[25] !== want.low_batt)    report_mismatch("low_battery", word[25],
                                                               want.low_batt);
            if (word[31:26] !== 6'd0)          report_mismatch("fill bits", word[31:26], 0);
         end
      endtask

   endclass

endpackage

@@ tb/sv/tb_battery_fuel_gauge_top.sv @@
// tb_battery_fuel_gauge_top: drives ticks and register writes into the fuel gauge
// and checks every result against the predictor; depends on bfg_pkg and bfg_tb_pkg

`timescale 1ns / 1ps

module tb_battery_fuel_gauge_top;

   import bfg_pkg::*;
   import bfg_tb_pkg::*;

   localparam int WINDOW_LEN      = 1;
   localparam int PHASE_COUNT     = 6;
   localparam int TICKS_PER_PHASE = 280;
   localparam int DRAIN_CYCLES    = 8;
   localparam int STALL_LIMIT     = 3000;
   localparam int DIRECTED_COUNT  = 19;

   // directed ticks: sample a, b, c, dc pin, vbus pin
   localparam int DIRECTED_TICKS [DIRECTED_COUNT][5] = '{
      '{0, 0, 0, 0, 0},             // all zero
      '{4095, 4095, 4095, 0, 0},    // full scale, above every band
      '{0, 4095, 2048, 1, 0},       // adapter, third reading in the middle
      '{4095, 0, 100, 0, 1},        // usb, first reading the largest
      '{10, 20, 5, 1, 1},           // both pins, adapter wins
      '{10, 20, 30, 0, 1},          // third reading the largest
      '{7, 7, 3, 0, 0},             // two equal readings, third lower
      '{1160, 1160, 1160, 0, 0},    // just above the lowest band
      '{1159, 1159, 1159, 0, 0},    // top of the lowest band
      '{1671, 1671, 1671, 0, 1},    // top of the charger table, full
      '{1672, 1672, 1672, 0, 1},    // just past the charger table
      '{1535, 1535, 1535, 0, 0},    // just past the battery table
      '{1534, 1534, 1534, 0, 0},    // top of the battery table
      '{1091, 1091, 1091, 0, 0},    // just under the low threshold
      '{1092, 1092, 1092, 0, 0},    // just over the low threshold
      '{1400, 1400, 1400, 1, 0},    // charger at 99 percent
      '{1200, 1200, 1200, 1, 0},
      '{4095, 0, 4095, 1, 0},
      '{2048, 0, 4095, 0, 1}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   fuel_gauge_scoreboard #(WINDOW_LEN) sb;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned threshold_now;
   int unsigned stall_cycles;
   bit          pin_dc;
   bit          pin_vbus;

   battery_fuel_gauge_top #(
      .WINDOW_LEN (WINDOW_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [REQ_DATA_W-1:0] pack_tick(int unsigned a, int unsigned b,
                                                       int unsigned c, bit dc, bit vbus);
      return {2'b00, vbus, dc, c[11:0], b[11:0], a[11:0]};
   endfunction

   // random tick: median mostly inside the band tables, pins changing now and then
   function automatic logic [REQ_DATA_W-1:0] random_tick();
      int unsigned mid, pick, tmp;
      int          target;
      int unsigned vals [3];
      pick = $urandom_range(99);
      if (pick < 55) begin
         mid = $urandom_range(1680, 1150);
      end else if (pick < 65) begin
         target = int'(threshold_now) * MV_DIVISOR / 1000 + int'($urandom_range(6)) - 3;
         mid = (target < 0) ? 0 : ((target > 4095) ? 4095 : target);
      end else if (pick < 85) begin
         mid = $urandom_range(4095);
      end else begin
         mid = $urandom_range(1) ? $urandom_range(3) : 4095 - $urandom_range(3);
      end
      vals[0] = ($urandom_range(9) == 0) ? mid : $urandom_range(mid, 0);
      vals[1] = mid;
      vals[2] = ($urandom_range(9) == 0) ? mid : $urandom_range(4095, mid);
      // shuffle the three readings
      pick = $urandom_range(2);
      tmp = vals[0]; vals[0] = vals[pick]; vals[pick] = tmp;
      pick = $urandom_range(2, 1);
      tmp = vals[1]; vals[1] = vals[pick]; vals[pick] = tmp;
      // some ticks with unrelated readings
      if ($urandom_range(4) == 0) begin
         foreach (vals[i]) vals[i] = $urandom_range(4095);
      end
      if ($urandom_range(9) == 0) begin
         pin_dc   = 1'($urandom_range(1));
         pin_vbus = 1'($urandom_range(1));
      end
      return pack_tick(vals[0], vals[1], vals[2], pin_dc, pin_vbus);
   endfunction

   // one request transaction, with random idle cycles ahead of it
   task automatic send_tick(logic [REQ_DATA_W-1:0] item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(item);
   endtask

   // one register write; the caller lowers csr_valid after the last one
   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, value);
      if (idx == CSR_LOW_THRESHOLD) threshold_now = value;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random backpressure, check every accepted transaction
   initial begin
      forever begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_battery_fuel_gauge_top NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // main sequence: reset, then phases of register settings and ticks
   initial begin : stimulus
      int unsigned thr, start_cnt, change_cnt, dflt;
      sb            = new();
      send_idle_pct = 12;
      recv_idle_pct = 64;
      threshold_now = 3200;
      pin_dc        = 1'b0;
      pin_vbus      = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_LOW_THRESHOLD;
      csr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // idle pattern: sender light, then receiver light, then none
         case (phase / 2)
            0: begin send_idle_pct = 12; recv_idle_pct = 64; end
            1: begin send_idle_pct = 64; recv_idle_pct = 12; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase

         case (phase)
            0: begin thr = 3200;  start_cnt = 30; change_cnt = 3;  dflt = 95;  end
            1: begin thr = 0;     start_cnt = 0;  change_cnt = 0;  dflt = 0;   end
            2: begin thr = 16383; start_cnt = 31; change_cnt = 31; dflt = 127; end
            3: begin thr = 12008; start_cnt = 31; change_cnt = 31; dflt = 100; end
            default: begin
               thr        = $urandom_range(16383);
               start_cnt  = $urandom_range(31);
               change_cnt = $urandom_range(31);
               dflt       = $urandom_range(127);
            end
         endcase

         if (phase > 0) begin
            req_tvalid <= 1'b0;
            wait_drained();
         end
         write_register(CSR_LOW_THRESHOLD, CSR_DATA_W'(thr));
         write_register(CSR_START_REFRESH, CSR_DATA_W'(start_cnt));
         write_register(CSR_CHANGE_REFRESH, CSR_DATA_W'(change_cnt));
         write_register(CSR_DEFAULT_LEVEL, CSR_DATA_W'(dflt));
         csr_valid <= 1'b0;

         if (phase == 0) begin
            for (int i = 0; i < DIRECTED_COUNT; i++) begin
               send_tick(pack_tick(DIRECTED_TICKS[i][0], DIRECTED_TICKS[i][1],
                                   DIRECTED_TICKS[i][2], 1'(DIRECTED_TICKS[i][3]),
                                   1'(DIRECTED_TICKS[i][4])));
            end
         end
         repeat (TICKS_PER_PHASE) send_tick(random_tick());
      end

      req_tvalid <= 1'b0;
      wait_drained();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_battery_fuel_gauge_top OK");
      end else begin
         $display("tb_battery_fuel_gauge_top NOT OK");
      end
      $finish;
   end

endmodule
